// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define IQM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define IQM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/iqm_pkg.sv -----
// ----------------------------------------------------------------------------
// iqm_pkg
// types, constants and the rrc coefficient table of the i/q mapper and shaper
// ----------------------------------------------------------------------------
package iqm_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int TAP_COUNT       = 33;
    localparam int UPSAMPLE_FACTOR = 4;
    localparam int HIST_DEPTH      = 8;
    localparam int MAC_LANES       = 9;
    localparam int GROUP_SIZE      = 3;
    localparam int MAC_GROUPS      = MAC_LANES / GROUP_SIZE;
    localparam int COEF_W          = 18;
    localparam int PROD_W          = SAMPLE_W + COEF_W;
    localparam int ACC_W           = PROD_W + 4;
    localparam int FRAC_BITS       = 16;
    localparam int TAP_IDX_W       = 6;
    localparam int PHASE_W         = 2;
    localparam int SYMBOL_W        = 4;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int SYMQ_DEPTH      = 2;
    localparam int OUT_DEPTH       = 4;
    localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W       = OUT_PTR_W + 1;

    // register indexes, taken from paddr[2]
    localparam logic REG_MODULATION = 1'b0;
    localparam logic REG_SHAPING    = 1'b1;

    // modulation codes
    localparam logic [1:0] MAP_BPSK  = 2'd0;
    localparam logic [1:0] MAP_QPSK  = 2'd1;
    localparam logic [1:0] MAP_8PSK  = 2'd2;
    localparam logic [1:0] MAP_16QAM = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] GAIN_I      = 12'sd1977;
    localparam logic signed [SAMPLE_W-1:0] GAIN_Q      = 12'sd1972;
    localparam logic signed [SAMPLE_W-1:0] GAIN_I_DIAG = 12'sd1397;
    localparam logic signed [SAMPLE_W-1:0] GAIN_Q_DIAG = 12'sd1394;
    localparam logic signed [SAMPLE_W-1:0] GAIN_I_THRD = 12'sd659;
    localparam logic signed [SAMPLE_W-1:0] GAIN_Q_THRD = 12'sd657;

    // unity gain in q16, used to pass the bare point through the mac
    localparam logic signed [COEF_W-1:0] BYPASS_COEF = 18'sd65536;
    localparam logic signed [ACC_W-1:0]  TRUNC_BIAS  = 34'sd65535;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] point_i;
        logic signed [SAMPLE_W-1:0] point_q;
        logic                       start;
        logic                       eos;
        logic                       shape;
    } sym_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
        logic                       last;
        logic                       done;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
        case (idx)
            6'd0:    tap_coef = 18'sd694;
            6'd1:    tap_coef = 18'sd380;
            6'd2:    tap_coef = -18'sd635;
            6'd3:    tap_coef = -18'sd1402;
            6'd4:    tap_coef = -18'sd1232;
            6'd5:    tap_coef = 18'sd196;
            6'd6:    tap_coef = 18'sd2143;
            6'd7:    tap_coef = 18'sd3086;
            6'd8:    tap_coef = 18'sd1736;
            6'd9:    tap_coef = -18'sd1802;
            6'd10:   tap_coef = -18'sd5583;
            6'd11:   tap_coef = -18'sd6514;
            6'd12:   tap_coef = -18'sd2103;
            6'd13:   tap_coef = 18'sd7798;
            6'd14:   tap_coef = 18'sd20381;
            6'd15:   tap_coef = 18'sd30913;
            6'd16:   tap_coef = 18'sd35015;
            6'd17:   tap_coef = 18'sd30913;
            6'd18:   tap_coef = 18'sd20381;
            6'd19:   tap_coef = 18'sd7798;
            6'd20:   tap_coef = -18'sd2103;
            6'd21:   tap_coef = -18'sd6514;
            6'd22:   tap_coef = -18'sd5583;
            6'd23:   tap_coef = -18'sd1802;
            6'd24:   tap_coef = 18'sd1736;
            6'd25:   tap_coef = 18'sd3086;
            6'd26:   tap_coef = 18'sd2143;
            6'd27:   tap_coef = 18'sd196;
            6'd28:   tap_coef = -18'sd1232;
            6'd29:   tap_coef = -18'sd1402;
            6'd30:   tap_coef = -18'sd635;
            6'd31:   tap_coef = 18'sd380;
            6'd32:   tap_coef = 18'sd694;
            default: tap_coef = '0;
        endcase
    endfunction

endpackage

// ----- sv/iqm_front.sv -----
// ----------------------------------------------------------------------------
// iqm_front
// config registers, symbol intake and constellation mapping
// ----------------------------------------------------------------------------
module iqm_front
    import iqm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      push,
    input  logic [SYMBOL_W-1:0]       symbol,
    input  logic                      start_stream,
    input  logic                      end_of_stream,
    input  queue_status_t             symq_status,
    output logic                      symq_push,
    output sym_item_t                 symq_item
);

    logic [1:0] modulation_reg;
    logic [1:0] modulation_next;
    logic       shaping_reg;
    logic       shaping_next;
    logic       cfg_write;

    logic signed [SAMPLE_W-1:0] map_i;
    logic signed [SAMPLE_W-1:0] map_q;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        modulation_next = modulation_reg;
        shaping_next    = shaping_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_MODULATION: modulation_next = pwdata[1:0];
                REG_SHAPING:    shaping_next    = pwdata[0];
                default:        modulation_next = modulation_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg <= MAP_BPSK;
            shaping_reg    <= 1'b0;
        end
        else
        begin
            modulation_reg <= modulation_next;
            shaping_reg    <= shaping_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODULATION: prdata = CFG_DATA_W'(modulation_reg);
            REG_SHAPING:    prdata = CFG_DATA_W'(shaping_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        case (modulation_reg)
            MAP_BPSK:
            begin
                map_i = symbol[0] ? -GAIN_I : GAIN_I;
                map_q = '0;
            end
            MAP_QPSK:
            begin
                map_i = (symbol[1:0] inside {2'd1, 2'd2}) ? -GAIN_I : GAIN_I;
                map_q = symbol[1] ? -GAIN_Q : GAIN_Q;
            end
            MAP_8PSK:
            begin
                case (symbol[2:0])
                    3'd0:    begin map_i = GAIN_I;       map_q = '0;           end
                    3'd1:    begin map_i = GAIN_I_DIAG;  map_q = GAIN_Q_DIAG;  end
                    3'd2:    begin map_i = '0;           map_q = GAIN_Q;       end
                    3'd3:    begin map_i = -GAIN_I_DIAG; map_q = GAIN_Q_DIAG;  end
                    3'd4:    begin map_i = -GAIN_I;      map_q = '0;           end
                    3'd5:    begin map_i = -GAIN_I_DIAG; map_q = -GAIN_Q_DIAG; end
                    3'd6:    begin map_i = '0;           map_q = -GAIN_Q;      end
                    default: begin map_i = GAIN_I_DIAG;  map_q = -GAIN_Q_DIAG; end
                endcase
            end
            default:
            begin
                case (symbol[3:2])
                    2'd0:    map_i = -GAIN_I;
                    2'd1:    map_i = -GAIN_I_THRD;
                    2'd2:    map_i = GAIN_I_THRD;
                    default: map_i = GAIN_I;
                endcase
                case (symbol[1:0])
                    2'd0:    map_q = -GAIN_Q;
                    2'd1:    map_q = -GAIN_Q_THRD;
                    2'd2:    map_q = GAIN_Q_THRD;
                    default: map_q = GAIN_Q;
                endcase
            end
        endcase
    end

    assign symq_push         = push && !symq_status.full;
    assign symq_item.point_i = map_i;
    assign symq_item.point_q = map_q;
    assign symq_item.start   = start_stream;
    assign symq_item.eos     = end_of_stream;
    assign symq_item.shape   = shaping_reg;

endmodule

// ----- sv/iqm_sym_queue.sv -----
// ----------------------------------------------------------------------------
// iqm_sym_queue
// two-entry queue of mapped symbols between the front and the shaper
// ----------------------------------------------------------------------------
module iqm_sym_queue
    import iqm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sym_item_t     wr_item,
    input  logic          rd_en,
    output sym_item_t     rd_item,
    output queue_status_t status
);

    sym_item_t  mem_reg [SYMQ_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign status.full  = (cnt_reg == 2'(SYMQ_DEPTH));
    assign status.empty = (cnt_reg == 2'd0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_item      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- sv/iqm_back.sv -----
// ----------------------------------------------------------------------------
// iqm_back
// point history, polyphase rrc mac pipeline and result queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iqm_back
    import iqm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sym_item_t     q_item,
    input  queue_status_t q_status,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output out_item_t     out_item
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic signed [SAMPLE_W-1:0] hist_i_reg [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_q_reg [HIST_DEPTH];

    logic signed [PROD_W-1:0] s1_prod_i_reg  [MAC_LANES];
    logic signed [PROD_W-1:0] s1_prod_q_reg  [MAC_LANES];
    logic signed [PROD_W-1:0] s1_prod_i_next [MAC_LANES];
    logic signed [PROD_W-1:0] s1_prod_q_next [MAC_LANES];
    logic signed [ACC_W-1:0]  s2_sum_i_reg   [MAC_GROUPS];
    logic signed [ACC_W-1:0]  s2_sum_q_reg   [MAC_GROUPS];
    logic signed [ACC_W-1:0]  s2_sum_i_next  [MAC_GROUPS];
    logic signed [ACC_W-1:0]  s2_sum_q_next  [MAC_GROUPS];

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s1_last_reg;
    logic s1_done_reg;
    logic s2_last_reg;
    logic s2_done_reg;

    out_item_t              out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   out_wr_reg;
    logic [OUT_PTR_W-1:0]   out_wr_next;
    logic [OUT_PTR_W-1:0]   out_rd_reg;
    logic [OUT_PTR_W-1:0]   out_rd_next;
    logic [OUT_CNT_W-1:0]   out_cnt_reg;
    logic [OUT_CNT_W-1:0]   out_cnt_next;
    logic [OUT_CNT_W-1:0]   inflight;

    logic      credit_ok;
    logic      issue;
    logic      last_phase;
    logic      out_push;
    logic      out_pop;
    out_item_t out_new;

    logic signed [ACC_W-1:0] total_i;
    logic signed [ACC_W-1:0] total_q;
    logic signed [ACC_W-1:0] adj_i;
    logic signed [ACC_W-1:0] adj_q;

    // sequencer: one sample issued per cycle while a symbol is queued and result slots remain
    assign inflight   = out_cnt_reg + OUT_CNT_W'(s1_valid_reg) + OUT_CNT_W'(s2_valid_reg);
    assign credit_ok  = inflight < OUT_CNT_W'(OUT_DEPTH);
    assign issue      = !q_status.empty && credit_ok;
    assign last_phase = !q_item.shape || (phase_reg == PHASE_LAST);
    assign q_pop      = issue && last_phase;

    always_comb
    begin
        phase_next = phase_reg;
        if (issue)
        begin
            phase_next = last_phase ? PHASE_FIRST : phase_reg + 2'd1;
        end
    end

    // mac lanes, one per point of the history window
    for (genvar m = 0; m < MAC_LANES; m++)
    begin : g_lane
        logic signed [SAMPLE_W-1:0] op_i;
        logic signed [SAMPLE_W-1:0] op_q;
        logic signed [COEF_W-1:0]   coef;
        logic [TAP_IDX_W-1:0]       tap_idx;

        assign tap_idx = {4'(m), phase_reg};

        if (m == 0)
        begin : g_cur
            assign op_i = q_item.point_i;
            assign op_q = q_item.point_q;
            assign coef = q_item.shape ? tap_coef(tap_idx) : BYPASS_COEF;
        end
        else
        begin : g_old
            assign op_i = q_item.start ? '0 : hist_i_reg[m-1];
            assign op_q = q_item.start ? '0 : hist_q_reg[m-1];
            assign coef = q_item.shape ? tap_coef(tap_idx) : '0;
        end

        assign s1_prod_i_next[m] = PROD_W'(op_i) * PROD_W'(coef);
        assign s1_prod_q_next[m] = PROD_W'(op_q) * PROD_W'(coef);
    end

    for (genvar g = 0; g < MAC_GROUPS; g++)
    begin : g_group
        assign s2_sum_i_next[g] = ACC_W'(s1_prod_i_reg[GROUP_SIZE*g])
                                + ACC_W'(s1_prod_i_reg[GROUP_SIZE*g+1])
                                + ACC_W'(s1_prod_i_reg[GROUP_SIZE*g+2]);
        assign s2_sum_q_next[g] = ACC_W'(s1_prod_q_reg[GROUP_SIZE*g])
                                + ACC_W'(s1_prod_q_reg[GROUP_SIZE*g+1])
                                + ACC_W'(s1_prod_q_reg[GROUP_SIZE*g+2]);
    end

    // final sum, q16 to integer truncating toward zero
    always_comb
    begin
        total_i = s2_sum_i_reg[0] + s2_sum_i_reg[1] + s2_sum_i_reg[2];
        total_q = s2_sum_q_reg[0] + s2_sum_q_reg[1] + s2_sum_q_reg[2];
        adj_i   = total_i[ACC_W-1] ? total_i + TRUNC_BIAS : total_i;
        adj_q   = total_q[ACC_W-1] ? total_q + TRUNC_BIAS : total_q;
        out_new.sample_i = adj_i[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        out_new.sample_q = adj_q[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        out_new.last     = s2_last_reg;
        out_new.done     = s2_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_i_reg[k] <= '0;
                hist_q_reg[k] <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (q_pop)
            begin
                hist_i_reg[0] <= q_item.point_i;
                hist_q_reg[0] <= q_item.point_q;
                for (int k = 1; k < HIST_DEPTH; k++)
                begin
                    hist_i_reg[k] <= q_item.start ? '0 : hist_i_reg[k-1];
                    hist_q_reg[k] <= q_item.start ? '0 : hist_q_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_i_reg <= s1_prod_i_next;
        s1_prod_q_reg <= s1_prod_q_next;
        s1_last_reg   <= last_phase;
        s1_done_reg   <= last_phase && q_item.eos;
        s2_sum_i_reg  <= s2_sum_i_next;
        s2_sum_q_reg  <= s2_sum_q_next;
        s2_last_reg   <= s1_last_reg;
        s2_done_reg   <= s1_done_reg;
    end

    // result queue
    assign out_push = s2_valid_reg;
    assign empty    = (out_cnt_reg == '0);
    assign out_pop  = pop && !empty;
    assign out_item = out_mem_reg[out_rd_reg];

    always_comb
    begin
        out_wr_next  = out_push ? out_wr_reg + 1'b1 : out_wr_reg;
        out_rd_next  = out_pop ? out_rd_reg + 1'b1 : out_rd_reg;
        out_cnt_next = out_cnt_reg + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            out_wr_reg  <= out_wr_next;
            out_rd_reg  <= out_rd_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem_reg[out_wr_reg] <= out_new;
        end
    end

    `IQM_ASSERT(a_credit_bound, inflight <= OUT_CNT_W'(OUT_DEPTH), "result slots overcommitted")
    `IQM_ASSERT_NEVER(a_out_overflow, out_push && (out_cnt_reg == OUT_CNT_W'(OUT_DEPTH)) && !out_pop, "result queue overflow")
    `IQM_ASSERT(a_bypass_single, (issue && !q_item.shape) |-> (phase_reg == PHASE_FIRST), "bypass request issued mid-symbol")
    `IQM_ASSERT(a_phase_wrap, (issue && q_item.shape && (phase_reg == PHASE_LAST)) |=> (phase_reg == PHASE_FIRST), "phase did not wrap after last sample")

endmodule

// ----- sv/iq_mapper_rrc_shaper.sv -----
// ----------------------------------------------------------------------------
// iq_mapper_rrc_shaper
// bpsk/qpsk/8psk/16qam mapper with 4x upsampling 33-tap rrc pulse shaper
// ----------------------------------------------------------------------------
// symbols enter through a queue-style port: a request is taken on a rising
// edge with push high and full low. results leave the same way: the oldest
// sample sits on sample_i/sample_q while empty is low and is taken on an edge
// with pop high. modulation (0x0) and shaping_enable (0x4) must be written
// over the apb port only while the block is idle, which the block does not
// check; pready is always high. with shaping on, each symbol gives four
// filtered samples; the mac pipeline issues one sample a cycle while a symbol
// is queued and result slots remain. with shaping off one raw point comes out
// per symbol, one symbol per cycle under the same conditions. a symbol's
// results pass the product register and the adder register and are then
// written to the result queue. a two-entry symbol queue and a four-entry
// result queue decouple the sides; when pop stays low the result queue fills,
// issue stops, and full rises once the symbol queue holds two symbols.
// reset clears the config registers, both queues and the point history.
// ----------------------------------------------------------------------------
module iq_mapper_rrc_shaper
    import iqm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_W-1:0]      paddr,
    input  logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  logic [SYMBOL_W-1:0]        symbol,
    input  logic                       start_stream,
    input  logic                       end_of_stream,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample_i,
    output logic signed [SAMPLE_W-1:0] sample_q,
    output logic                       last_of_symbol,
    output logic                       stream_done
);

    queue_status_t symq_status;
    sym_item_t     symq_wr_item;
    sym_item_t     symq_rd_item;
    logic          symq_push;
    logic          symq_pop;
    out_item_t     out_item;

    iqm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .symbol        (symbol),
        .start_stream  (start_stream),
        .end_of_stream (end_of_stream),
        .symq_status   (symq_status),
        .symq_push     (symq_push),
        .symq_item     (symq_wr_item)
    );

    iqm_sym_queue u_symq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (symq_push),
        .wr_item (symq_wr_item),
        .rd_en   (symq_pop),
        .rd_item (symq_rd_item),
        .status  (symq_status)
    );

    iqm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (symq_rd_item),
        .q_status (symq_status),
        .q_pop    (symq_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    assign full           = symq_status.full;
    assign sample_i       = out_item.sample_i;
    assign sample_q       = out_item.sample_q;
    assign last_of_symbol = out_item.last;
    assign stream_done    = out_item.done;

endmodule
